[rtl/btlv_pkg.sv]
// shared constants and types for the ber tlv header parser
// no dependencies; imported by ber_tlv_header_parser_top
package btlv_pkg;

  localparam int unsigned DefMaxTagBytes = 4;
  localparam int unsigned TagW           = 32;
  localparam int unsigned LenW           = 32;
  localparam int unsigned ByteW          = 8;
  localparam int unsigned KindW          = 2;
  localparam int unsigned PhaseW         = 3;
  localparam int unsigned CntW           = 3;
  localparam int unsigned OutDataW       = TagW + LenW + ByteW;

  // parser phase codes
  localparam logic [PhaseW-1:0] PH_TAG_FIRST = 3'd0;
  localparam logic [PhaseW-1:0] PH_TAG_MORE  = 3'd1;
  localparam logic [PhaseW-1:0] PH_LEN_FIRST = 3'd2;
  localparam logic [PhaseW-1:0] PH_LEN_MORE  = 3'd3;
  localparam logic [PhaseW-1:0] PH_CONTENT   = 3'd4;
  localparam logic [PhaseW-1:0] PH_ERROR     = 3'd5;

  // result kinds
  localparam logic [KindW-1:0] K_HEADER  = 2'd0;
  localparam logic [KindW-1:0] K_CONTENT = 2'd1;
  localparam logic [KindW-1:0] K_ERROR   = 2'd2;

  // bit masks of the encoding
  localparam logic [ByteW-1:0] TAG_LOW_MASK = 8'h1f;
  localparam logic [ByteW-1:0] LOW7_MASK    = 8'h7f;
  localparam logic [ByteW-1:0] MSB_MASK     = 8'h80;

  localparam logic [CntW-1:0] MAX_LEN_RESET = 3'd4;
  localparam logic [CntW-1:0] MAX_LEN_CAP   = 3'd4;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [TagW-1:0]  tag_value;
    logic [LenW-1:0]  length_value;
    logic [ByteW-1:0] content_byte;
    logic             last_of_record;
  } result_t;

endpackage

[rtl/ber_tlv_header_parser_top.sv]
// ber tlv header parser: one encoded byte per request, emits header,
// content and error results; depends on btlv_pkg
//
// output: a result appears on the out channel in the cycle after the byte
// that causes it is accepted
// throughput: one byte per cycle while the output is not held; the single
// result register frees up in the same cycle its result is taken, so the
// input never stalls on a draining output
// reset: rst_n synchronous active low; parser returns to the first tag byte,
// error cleared, max_length_octets back to 4, output register empty
module ber_tlv_header_parser_top #(
  parameter int unsigned MAX_TAG_BYTES = btlv_pkg::DefMaxTagBytes
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // byte stream in
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [btlv_pkg::ByteW-1:0]    in_tdata,   // [7:0] data_byte
  input  logic                          in_tuser,   // [0] start_of_record
  // results out
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [btlv_pkg::OutDataW-1:0] out_tdata,  // [31:0] tag_value,
                                                    // [63:32] length_value,
                                                    // [71:64] content_byte
  output logic [btlv_pkg::KindW-1:0]    out_tuser,  // [1:0] kind
  output logic                          out_tlast,  // last_of_record
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [btlv_pkg::CntW-1:0]     cfg_data    // max_length_octets
);

  import btlv_pkg::*;

  localparam logic [CntW-1:0] MaxTagCnt = CntW'(MAX_TAG_BYTES);

  // parser state
  logic [PhaseW-1:0] phase_r, phase_nxt;
  logic [TagW-1:0]   tag_acc_r, tag_acc_nxt;
  logic [CntW-1:0]   tag_cnt_r, tag_cnt_nxt;
  logic [LenW-1:0]   len_acc_r, len_acc_nxt;
  logic [CntW-1:0]   len_left_r, len_left_nxt;
  logic [LenW-1:0]   content_left_r, content_left_nxt;
  logic [CntW-1:0]   max_len_r;

  // result register
  logic              out_valid_r;
  result_t           res_r, res_nxt;
  logic              res_fire;

  logic              in_acc;
  logic [ByteW-1:0]  b;
  logic [PhaseW-1:0] cur_phase;
  logic [CntW-1:0]   limit;
  logic [ByteW-1:0]  len_cnt;
  logic [LenW-1:0]   hdr_len;
  logic              hdr_go;
  logic [LenW-1:0]   content_dec;

  // accept whenever the result register is empty or drains this cycle
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign b         = in_tdata;

  // start of record forces a fresh tag and drops a latched error
  assign cur_phase = in_tuser ? PH_TAG_FIRST : phase_r;

  // clamp the configured length-octet limit to 1..4
  always_comb begin
    if (max_len_r == '0) begin
      limit = CntW'(1);
    end else if (max_len_r > MAX_LEN_CAP) begin
      limit = MAX_LEN_CAP;
    end else begin
      limit = max_len_r;
    end
  end

  assign len_cnt     = b & LOW7_MASK;
  assign content_dec = content_left_r - LenW'(1);

  always_comb begin
    phase_nxt        = phase_r;
    tag_acc_nxt      = tag_acc_r;
    tag_cnt_nxt      = tag_cnt_r;
    len_acc_nxt      = len_acc_r;
    len_left_nxt     = len_left_r;
    content_left_nxt = content_left_r;
    res_fire         = 1'b0;
    res_nxt          = '0;
    hdr_go           = 1'b0;
    hdr_len          = len_acc_r;

    unique case (cur_phase)
      PH_ERROR: begin
        // latched: swallow bytes until start of record
        phase_nxt = PH_ERROR;
      end
      PH_TAG_MORE: begin
        if (tag_cnt_r >= MaxTagCnt ||
            (tag_cnt_r == CntW'(1) && (b & LOW7_MASK) == '0)) begin
          phase_nxt = PH_ERROR;
          res_fire  = 1'b1;
          res_nxt   = '{kind: K_ERROR, tag_value: tag_acc_r, length_value: '0,
                        content_byte: b, last_of_record: 1'b0};
        end else begin
          tag_acc_nxt = {tag_acc_r[TagW-ByteW-1:0], b};
          tag_cnt_nxt = tag_cnt_r + CntW'(1);
          if ((b & MSB_MASK) == '0) begin
            phase_nxt = PH_LEN_FIRST;
          end
        end
      end
      PH_LEN_FIRST: begin
        len_acc_nxt = '0;
        if ((b & MSB_MASK) == '0) begin
          // short form
          hdr_go  = 1'b1;
          hdr_len = LenW'(b);
        end else if (len_cnt == '0) begin
          // 0x80 taken as zero length
          hdr_go  = 1'b1;
          hdr_len = '0;
        end else if (len_cnt > ByteW'(limit)) begin
          phase_nxt = PH_ERROR;
          res_fire  = 1'b1;
          res_nxt   = '{kind: K_ERROR, tag_value: tag_acc_r, length_value: '0,
                        content_byte: b, last_of_record: 1'b0};
        end else begin
          len_left_nxt = len_cnt[CntW-1:0];
          phase_nxt    = PH_LEN_MORE;
        end
      end
      PH_LEN_MORE: begin
        len_acc_nxt  = {len_acc_r[LenW-ByteW-1:0], b};
        len_left_nxt = len_left_r - CntW'(1);
        if (len_left_r == CntW'(1)) begin
          hdr_go  = 1'b1;
          hdr_len = {len_acc_r[LenW-ByteW-1:0], b};
        end
      end
      PH_CONTENT: begin
        content_left_nxt = content_dec;
        res_fire         = 1'b1;
        res_nxt          = '{kind: K_CONTENT, tag_value: tag_acc_r,
                             length_value: len_acc_r, content_byte: b,
                             last_of_record: (content_dec == '0)};
        if (content_dec == '0) begin
          phase_nxt = PH_TAG_FIRST;
        end
      end
      default: begin
        // first tag byte, also covers unused codes
        tag_acc_nxt      = TagW'(b);
        tag_cnt_nxt      = CntW'(1);
        len_acc_nxt      = '0;
        len_left_nxt     = '0;
        content_left_nxt = '0;
        phase_nxt        = ((b & TAG_LOW_MASK) == TAG_LOW_MASK) ? PH_TAG_MORE
                                                                 : PH_LEN_FIRST;
      end
    endcase

    // header complete: zero length closes the record at once
    if (hdr_go) begin
      len_acc_nxt      = hdr_len;
      content_left_nxt = hdr_len;
      len_left_nxt     = '0;
      res_fire         = 1'b1;
      res_nxt          = '{kind: K_HEADER, tag_value: tag_acc_r,
                           length_value: hdr_len, content_byte: '0,
                           last_of_record: (hdr_len == '0)};
      phase_nxt        = (hdr_len == '0) ? PH_TAG_FIRST : PH_CONTENT;
    end
  end

  // state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_TAG_FIRST;
      tag_acc_r      <= '0;
      tag_cnt_r      <= '0;
      len_acc_r      <= '0;
      len_left_r     <= '0;
      content_left_r <= '0;
      max_len_r      <= MAX_LEN_RESET;
    end else begin
      if (in_acc) begin
        phase_r        <= phase_nxt;
        tag_acc_r      <= tag_acc_nxt;
        tag_cnt_r      <= tag_cnt_nxt;
        len_acc_r      <= len_acc_nxt;
        len_left_r     <= len_left_nxt;
        content_left_r <= content_left_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        max_len_r <= cfg_data;
      end
    end
  end

  // result register: control reset, payload free running
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= res_fire;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.kind;
  assign out_tdata  = {res_r.content_byte, res_r.length_value, res_r.tag_value};
  assign out_tlast  = res_r.last_of_record;

  // error results carry no length and never close a record
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == K_ERROR) |-> (out_tdata[63:32] == '0 && !out_tlast))
    else $error("error result with length or last set");

  // a header flagged last must have zero length
  a_hdr_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == K_HEADER && out_tlast) |-> (out_tdata[63:32] == '0))
    else $error("last header with nonzero length");

  // bytes during a latched error produce nothing
  a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_tuser && phase_r == PH_ERROR) |=> !out_tvalid)
    else $error("result emitted while error latched");

  // the final content byte is flagged last
  a_content_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_tuser && phase_r == PH_CONTENT && content_left_r == LenW'(1))
      |=> (out_tvalid && out_tlast && out_tuser == K_CONTENT))
    else $error("final content byte not flagged last");

endmodule

[verif/tlv_tb_pkg.sv]
// byte-level ber tlv parser model and the ordered store of results it predicts
// depends on btlv_pkg; used by tb_top
package tlv_tb_pkg;
  import btlv_pkg::*;

  class tlv_parse_board;
    result_t           parsed_q[$];
    int unsigned       mismatches;
    logic [CntW-1:0]   max_len_octets;
    logic [PhaseW-1:0] phase;
    logic [TagW-1:0]   tag_acc;
    logic [CntW-1:0]   tag_bytes;
    logic [LenW-1:0]   len_acc;
    logic [6:0]        len_bytes_left;
    logic [LenW-1:0]   content_left;
    logic              err_latched;

    function new();
      mismatches     = 0;
      max_len_octets = MAX_LEN_RESET;
      phase          = PH_TAG_FIRST;
      tag_acc        = '0;
      tag_bytes      = '0;
      len_acc        = '0;
      len_bytes_left = '0;
      content_left   = '0;
      err_latched    = 1'b0;
    endfunction

    function void set_max_len(logic [CntW-1:0] v);
      max_len_octets = v;
    endfunction

    function int pending();
      return parsed_q.size();
    endfunction

    function void push(logic [KindW-1:0] k, logic [ByteW-1:0] b, logic last);
      result_t r;
      r.kind           = k;
      r.tag_value      = tag_acc;
      r.length_value   = (k == K_ERROR) ? '0 : len_acc;
      r.content_byte   = b;
      r.last_of_record = last;
      parsed_q.push_back(r);
    endfunction

    function void fault(logic [ByteW-1:0] b);
      err_latched = 1'b1;
      phase       = PH_ERROR;
      push(K_ERROR, b, 1'b0);
    endfunction

    function void header_done();
      content_left   = len_acc;
      len_bytes_left = '0;
      phase          = (len_acc == 0) ? PH_TAG_FIRST : PH_CONTENT;
      push(K_HEADER, '0, len_acc == 0);
    endfunction

    // one accepted request: advance the parse and queue any result it causes
    function void parse_byte(logic [ByteW-1:0] b, logic sor);
      logic [6:0]      n;
      logic [CntW-1:0] lim;
      if (sor) begin
        err_latched = 1'b0;
        phase       = PH_TAG_FIRST;
      end
      if (err_latched) return;
      case (phase)
        PH_TAG_MORE: begin
          if (tag_bytes >= DefMaxTagBytes) fault(b);
          else if (tag_bytes == 1 && (b & LOW7_MASK) == 0) fault(b);
          else begin
            tag_acc   = {tag_acc[TagW-9:0], b};
            tag_bytes = tag_bytes + 1'b1;
            if ((b & MSB_MASK) == 0) phase = PH_LEN_FIRST;
          end
        end
        PH_LEN_FIRST: begin
          len_acc = '0;
          n       = b[6:0];
          lim     = max_len_octets;
          if (lim < 1) lim = CntW'(1);
          if (lim > MAX_LEN_CAP) lim = MAX_LEN_CAP;
          if ((b & MSB_MASK) == 0) begin
            len_acc = {24'd0, b};
            header_done();
          end else if (n == 0) header_done();
          else if (n > lim) fault(b);
          else begin
            len_bytes_left = n;
            phase          = PH_LEN_MORE;
          end
        end
        PH_LEN_MORE: begin
          len_acc        = {len_acc[LenW-9:0], b};
          len_bytes_left = len_bytes_left - 1'b1;
          if (len_bytes_left == 0) header_done();
        end
        PH_CONTENT: begin
          content_left = content_left - 1;
          if (content_left == 0) phase = PH_TAG_FIRST;
          push(K_CONTENT, b, content_left == 0);
        end
        default: begin
          tag_acc        = {24'd0, b};
          tag_bytes      = CntW'(1);
          len_acc        = '0;
          len_bytes_left = '0;
          content_left   = '0;
          phase = ((b & TAG_LOW_MASK) == TAG_LOW_MASK) ? PH_TAG_MORE : PH_LEN_FIRST;
        end
      endcase
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      mismatches++;
    endtask

    task check_result(logic [KindW-1:0] k, logic [TagW-1:0] tag, logic [LenW-1:0] len,
                      logic [ByteW-1:0] b, logic last);
      result_t want;
      if (parsed_q.size() == 0) begin
        report($sformatf("result with nothing pending: kind %0d tag %h len %h byte %h",
                         k, tag, len, b));
        return;
      end
      want = parsed_q.pop_front();
      if (k !== want.kind)
        report($sformatf("kind %0d, want %0d", k, want.kind));
      if (tag !== want.tag_value)
        report($sformatf("tag_value %h, want %h", tag, want.tag_value));
      if (len !== want.length_value)
        report($sformatf("length_value %h, want %h", len, want.length_value));
      if (b !== want.content_byte)
        report($sformatf("content_byte %h, want %h", b, want.content_byte));
      if (last !== want.last_of_record)
        report($sformatf("last_of_record %b, want %b", last, want.last_of_record));
    endtask
  endclass

endpackage

[verif/tb_top.sv]
// top-level testbench for ber_tlv_header_parser_top: drives byte streams of
// tlv records, writes max_length_octets between phases, checks every result
// depends on btlv_pkg, tlv_tb_pkg and the rtl of the parser
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import btlv_pkg::*;
  import tlv_tb_pkg::*;

  localparam int unsigned RUN_LIMIT   = 200000;  // cycles before giving up
  localparam int unsigned HOLD_CYCLES = 300;     // long output stall
  localparam int unsigned DRAIN_WAIT  = 8;       // quiet cycles after the last result
  localparam int unsigned PHASE_ITEMS = 50;      // requests per configuration phase

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [ByteW-1:0]    in_tdata;
  logic                in_tuser;
  logic                out_tvalid;
  logic                out_tready;
  logic [OutDataW-1:0] out_tdata;
  logic [KindW-1:0]    out_tuser;
  logic                out_tlast;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CntW-1:0]     cfg_data;

  tlv_parse_board board = new();

  int unsigned     cycle_count = 0;
  int unsigned     items_sent;
  int unsigned     hold_req_seq;     // bumped by the stimulus to ask for a long stall
  bit              quiet;            // no idling on either side while set
  bit              restart_next;     // next record must carry start_of_record
  logic [CntW-1:0] max_len_setting;  // mirror of the register for stimulus shaping

  ber_tlv_header_parser_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("[ber_tlv_header_parser_top] ERROR");
      $finish;
    end
  end

  // all handshakes sampled at the rising edge in one place: the result is
  // checked before the request of the same edge is parsed, so queue order
  // never depends on process scheduling
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready)
        board.check_result(out_tuser, out_tdata[TagW-1:0], out_tdata[TagW+LenW-1:TagW],
                           out_tdata[OutDataW-1:TagW+LenW], out_tlast);
      if (in_tvalid && in_tready)
        board.parse_byte(in_tdata, in_tuser);
      if (cfg_valid && cfg_ready)
        board.set_max_len(cfg_data);
    end
  end

  // mostly short gaps, a few long ones, none while quiet
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // result receiver: random stalls, plus one long hold on request that is
  // counted here so the sender keeps pushing while the parser backs up
  initial begin
    int          stall_left;
    int          r;
    int unsigned hold_seen;
    stall_left = 0;
    hold_seen  = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_req_seq) begin
        hold_seen  = hold_req_seq;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else if (quiet) begin
        out_tready = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          out_tready = 1'b1;
        end else begin
          out_tready = 1'b0;
          stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(6, 30);
        end
      end
    end
  end

  // one byte request; enters and leaves at a falling edge, valid stays high
  // so a following request without a gap goes out back to back
  task automatic send_byte(input logic [ByteW-1:0] b, input logic sor, input bit counted);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    in_tuser  = sor;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    if (counted) items_sent++;
  endtask

  // bytes swallowed by a latched error
  task automatic send_ignored();
    logic [ByteW-1:0] b;
    repeat ($urandom_range(0, 2)) begin
      b = ByteW'($urandom);
      send_byte(b, 1'b0, 1'b0);
    end
    restart_next = 1'b1;
  endtask

  // one random record; fixed_len >= 0 gives a clean short-tag record with
  // that many content bytes
  task automatic send_record(input int fixed_len);
    logic [ByteW-1:0] b;
    logic [CntW-1:0]  lim;
    logic             sor;
    int               n_cont;
    int               n_len;
    int               n_body;
    int               r;
    int               i;
    bit               aborted;
    longint           content_len;
    sor          = restart_next || ($urandom_range(0, 1) == 1);
    restart_next = 1'b0;
    content_len  = 0;

    // raw noise now and then, parsed as whatever it happens to be
    if (fixed_len < 0 && $urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(1, 4)) begin
        b = ByteW'($urandom);
        send_byte(b, $urandom_range(0, 3) == 0, 1'b1);
      end
      restart_next = 1'b1;
      return;
    end

    // tag: single byte, or multi-byte with continuation bytes
    b = ByteW'($urandom);
    if (fixed_len >= 0 || $urandom_range(0, 99) < 65) begin
      if (b[4:0] == 5'h1f) b[4] = 1'b0;
      send_byte(b, sor, 1'b1);
    end else begin
      b[4:0] = 5'h1f;
      send_byte(b, sor, 1'b1);
      // four continuation bytes overrun the tag limit
      n_cont = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3) : 4;
      for (i = 0; i < n_cont; i++) begin
        b    = ByteW'($urandom);
        b[7] = (i != n_cont - 1);
        if (i == 0 && b[6:0] == 7'd0) b[0] = 1'b1;
        // malformed first continuation byte
        if (i == 0 && $urandom_range(0, 99) < 6) b[6:0] = 7'd0;
        send_byte(b, 1'b0, 1'b1);
        if (i == 0 && b[6:0] == 7'd0) begin
          send_ignored();
          return;
        end
      end
      if (n_cont == 4) begin
        send_ignored();
        return;
      end
    end

    // length
    lim = max_len_setting;
    if (lim < 1) lim = CntW'(1);
    if (lim > MAX_LEN_CAP) lim = MAX_LEN_CAP;
    r = $urandom_range(0, 99);
    if (fixed_len >= 0) begin
      content_len = fixed_len;
      b = ByteW'(fixed_len);
      send_byte(b, 1'b0, 1'b1);
    end else if (r < 45) begin
      content_len = $urandom_range(0, 6);
      b = ByteW'(content_len);
      send_byte(b, 1'b0, 1'b1);
    end else if (r < 50) begin
      content_len = $urandom_range(13, 127);
      b = ByteW'(content_len);
      send_byte(b, 1'b0, 1'b1);
    end else if (r < 55) begin
      send_byte(MSB_MASK, 1'b0, 1'b1);  // indefinite marker, read as zero length
    end else begin
      r = $urandom_range(0, 99);
      if (r < 85) n_len = $urandom_range(1, lim);
      else if (r < 97) n_len = $urandom_range(lim + 1, 7);
      else n_len = 127;
      b = {1'b1, n_len[6:0]};
      send_byte(b, 1'b0, 1'b1);
      if (n_len > lim) begin
        send_ignored();
        return;
      end
      // mostly leading zeros for short bodies, sometimes full random lengths
      r = $urandom_range(0, 99);
      for (i = 0; i < n_len; i++) begin
        if (r < 12) b = ByteW'($urandom);
        else b = (i == n_len - 1) ? ByteW'($urandom_range(0, 6)) : '0;
        content_len = (content_len << 8) | b;
        send_byte(b, 1'b0, 1'b1);
      end
    end

    // body: long bodies are cut short and the next record restarts parsing
    aborted = (fixed_len < 0 && content_len > 12);
    if (aborted) n_body = $urandom_range(1, 4);
    else n_body = int'(content_len);
    for (i = 0; i < n_body; i++) begin
      b   = ByteW'($urandom);
      sor = (fixed_len < 0) && ($urandom_range(0, 199) == 0);
      send_byte(b, sor, 1'b1);
      if (sor) aborted = 1'b1;
    end
    if (aborted) restart_next = 1'b1;
  endtask

  // wait until every predicted result has arrived, then let the block settle
  task automatic drain();
    while (board.pending() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_max_len(input logic [CntW-1:0] v);
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid       = 1'b0;
    max_len_setting = v;
  endtask

  initial begin
    // both extremes, the clamped values and the ones in between
    logic [CntW-1:0] settings [8];
    int unsigned     phase_end;
    int              ph;
    settings = '{3'd1, 3'd7, 3'd0, 3'd4, 3'd2, 3'd6, 3'd3, 3'd5};

    rst_n           = 1'b0;
    in_tvalid       = 1'b0;
    in_tdata        = '0;
    in_tuser        = 1'b0;
    cfg_valid       = 1'b0;
    cfg_data        = '0;
    quiet           = 1'b0;
    hold_req_seq    = 0;
    items_sent      = 0;
    restart_next    = 1'b0;
    max_len_setting = MAX_LEN_RESET;

    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed records at the reset setting of max_length_octets
    // short tag, short length, one content byte
    send_byte(8'h02, 1'b1, 1'b1);
    send_byte(8'h01, 1'b0, 1'b1);
    send_byte(8'h55, 1'b0, 1'b1);
    // indefinite length marker gives a zero-length header
    send_byte(8'h30, 1'b0, 1'b1);
    send_byte(8'h80, 1'b0, 1'b1);
    // three-byte tag, two content bytes at the byte extremes
    send_byte(8'h1f, 1'b0, 1'b1);
    send_byte(8'h81, 1'b0, 1'b1);
    send_byte(8'h7f, 1'b0, 1'b1);
    send_byte(8'h02, 1'b0, 1'b1);
    send_byte(8'hff, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b1);
    // first continuation byte with empty low seven bits
    send_byte(8'h3f, 1'b0, 1'b1);
    send_byte(8'h80, 1'b0, 1'b1);
    // dropped while the error is latched
    send_byte(8'h01, 1'b0, 1'b0);
    // tag runs past four bytes
    send_byte(8'hff, 1'b1, 1'b1);
    send_byte(8'h81, 1'b0, 1'b1);
    send_byte(8'h82, 1'b0, 1'b1);
    send_byte(8'h83, 1'b0, 1'b1);
    send_byte(8'h04, 1'b0, 1'b1);
    // long form, two length bytes, length one
    send_byte(8'h04, 1'b1, 1'b1);
    send_byte(8'h82, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'h01, 1'b0, 1'b1);
    send_byte(8'hee, 1'b0, 1'b1);
    // long-form count above the limit
    send_byte(8'h04, 1'b0, 1'b1);
    send_byte(8'h85, 1'b0, 1'b1);
    in_tvalid    = 1'b0;
    restart_next = 1'b1;

    // random phases, one register setting each
    for (ph = 0; ph < 8; ph++) begin
      drain();
      write_max_len(settings[ph]);
      quiet     = (ph == 2 || ph == 5);
      phase_end = items_sent + PHASE_ITEMS;
      // back-pressure: receiver stalls while a long record keeps coming
      if (ph == 0) begin
        hold_req_seq++;
        send_record(40);
      end
      while (items_sent < phase_end) send_record(-1);
      in_tvalid = 1'b0;
    end

    drain();
    if (board.mismatches == 0) begin
      $display("[ber_tlv_header_parser_top] OK");
    end else begin
      $display("[ber_tlv_header_parser_top] ERROR");
    end
    $finish;
  end

endmodule
